FILE: hdl/keyframe_vector_interpolator_top_macros.svh
// ----------------------------------------------------------------------------
// Keyframe vector interpolator assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_VECTOR_INTERPOLATOR_TOP_MACROS_SVH
`define KEYFRAME_VECTOR_INTERPOLATOR_TOP_MACROS_SVH

// Assert a property on every rising clock edge outside reset.
`define KVI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that a condition never holds outside reset.
`define KVI_ASSERT_NEVER(lbl, cond, msg) \
  `KVI_ASSERT(lbl, !(cond), msg)

`endif

FILE: hdl/kvi_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe vector interpolator package
// Table sizes, field widths, command and status codes.
// ----------------------------------------------------------------------------
package kvi_pkg;

  localparam int unsigned KeyDepth = 32;
  localparam int unsigned KeyAw    = (KeyDepth > 1) ? $clog2(KeyDepth) : 1;
  localparam int unsigned KeyCntW  = $clog2(KeyDepth + 1);

  localparam int unsigned ValW     = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StsW     = 3;
  localparam int unsigned InW      = 4 * ValW;
  localparam int unsigned OutW     = 3 * ValW;

  typedef enum logic [CmdW-1:0] {
    CmdLoad     = 2'd0,
    CmdQuery    = 2'd1,
    CmdClear    = 2'd2,
    CmdQueryAlt = 2'd3
  } cmd_e;

  typedef enum logic [StsW-1:0] {
    StsBlend   = 3'd0,
    StsHeld    = 3'd1,
    StsDefault = 3'd2,
    StsLoaded  = 3'd3,
    StsFull    = 3'd4,
    StsCleared = 3'd5
  } status_e;

  // One stored key: time and x/y/z values (x at index 0).
  typedef struct packed {
    logic [ValW-1:0]       t;
    logic [2:0][ValW-1:0]  val;
  } key_entry_t;

endpackage

FILE: hdl/kvi_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module kvi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/kvi_div.sv
// ----------------------------------------------------------------------------
// Ratio divider
// Restoring divider, one quotient bit per cycle: quo = (num << FracBits) / den
// for num < den.
// ----------------------------------------------------------------------------
module kvi_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [kvi_pkg::ValW-1:0]     num_i,
  input  logic [kvi_pkg::ValW-1:0]     den_i,
  output logic                         done_o,
  output logic [kvi_pkg::FracBits-1:0] quo_o
);
  import kvi_pkg::*;

  localparam int unsigned CntW = (FracBits > 1) ? $clog2(FracBits) : 1;

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic [ValW-1:0]     rem_q;
  logic [ValW-1:0]     den_q;
  logic [FracBits-1:0] quo_q;

  logic [ValW:0]       shifted;
  logic                take;
  logic [ValW-1:0]     rem_d;

  // Remainder stays below den, so the shifted value fits ValW + 1 bits.
  assign shifted = {rem_q, 1'b0};
  assign take    = shifted >= {1'b0, den_q};
  always_comb begin
    rem_d = shifted[ValW-1:0];
    if (take) begin
      rem_d = ValW'(shifted - {1'b0, den_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // Flag the cycle after the last quotient bit.
      done_q <= !start_i && busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(FracBits - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[FracBits-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: hdl/keyframe_vector_interpolator_top.sv
// ----------------------------------------------------------------------------
// Keyframe vector interpolator
// Key table of timed Q16.16 3-vectors with linear blend between the two keys
// that bracket a query time.
// ----------------------------------------------------------------------------
// One request is in work at a time. A query scans all stored keys: the key
// table sits in one RAM whose single read port scans one key per cycle. When
// a pair of keys brackets the time, the ratio comes from a divider that yields
// one bit per cycle, and the three components share one multiplier. A finished
// result waits in the output register while the next request is taken.
module keyframe_vector_interpolator_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // cfg_wdata_i: default_component
  input  logic                      cfg_we_i,
  input  logic [kvi_pkg::ValW-1:0]  cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // s_axis_tdata: key_time, key_x, key_y, key_z
  input  logic [kvi_pkg::InW-1:0]   s_axis_tdata,
  // s_axis_tuser: cmd
  input  logic [kvi_pkg::CmdW-1:0]  s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // m_axis_tdata: out_x, out_y, out_z
  output logic [kvi_pkg::OutW-1:0]  m_axis_tdata,
  // m_axis_tuser: status
  output logic [kvi_pkg::StsW-1:0]  m_axis_tuser
);
  import kvi_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StEval,
    StDiv,
    StMul,
    StAdd,
    StDone
  } state_e;

  localparam int unsigned ProdW = ValW + 1 + FracBits + 1;

  state_e               state_q;
  logic [KeyCntW-1:0]   count_q;
  logic [KeyCntW-1:0]   addr_q;
  logic [ValW-1:0]      default_q;
  logic                 rd_vld_q;
  logic                 have_pre_q;
  logic                 have_post_q;
  logic [1:0]           comp_q;
  status_e              status_q;
  logic                 m_valid_q;
  logic [OutW-1:0]      m_data_q;
  logic [StsW-1:0]      m_user_q;

  logic [ValW-1:0]      t_q;
  key_entry_t           pre_q;
  key_entry_t           post_q;
  logic [2:0][ValW-1:0] res_q;
  logic [ProdW-1:0]     prod_q;

  logic                 accept;
  cmd_e                 cmd;
  logic                 table_full;
  logic                 ram_we;
  logic                 ram_re;
  key_entry_t           ram_wdata;
  key_entry_t           ram_rdata;
  logic                 upd_pre;
  logic                 upd_post;
  logic                 div_start;
  logic                 div_done;
  logic [FracBits-1:0]  ratio;
  logic [ValW-1:0]      div_num;
  logic [ValW-1:0]      div_den;
  logic signed [ValW:0] diff;
  logic [ProdW-1:0]     prod_d;
  logic [ValW-1:0]      comp_a;
  logic [ValW-1:0]      comp_b;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);
  assign table_full    = (count_q >= KeyCntW'(KeyDepth));

  // Key table: append on load, scan on query.
  assign ram_we    = accept && (cmd == CmdLoad) && !table_full;
  assign ram_wdata = '{t: s_axis_tdata[ValW-1:0], val: s_axis_tdata[InW-1:ValW]};
  assign ram_re    = (state_q == StScan) && (addr_q < count_q);

  kvi_ram #(
    .Width ($bits(key_entry_t)),
    .Depth (KeyDepth)
  ) u_kvi_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[KeyAw-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q[KeyAw-1:0]),
    .rdata_o (ram_rdata)
  );

  // Keep the first key with the best time on each side; equal times drop out.
  assign upd_pre  = rd_vld_q && ($signed(ram_rdata.t) < $signed(t_q)) &&
                    (!have_pre_q || ($signed(ram_rdata.t) > $signed(pre_q.t)));
  assign upd_post = rd_vld_q && ($signed(ram_rdata.t) > $signed(t_q)) &&
                    (!have_post_q || ($signed(ram_rdata.t) < $signed(post_q.t)));

  // pre.t < t < post.t, so both differences are positive and fit ValW bits.
  assign div_start = (state_q == StEval) && have_pre_q && have_post_q;
  assign div_num   = ValW'($signed({t_q[ValW-1], t_q}) -
                           $signed({pre_q.t[ValW-1], pre_q.t}));
  assign div_den   = ValW'($signed({post_q.t[ValW-1], post_q.t}) -
                           $signed({pre_q.t[ValW-1], pre_q.t}));

  kvi_div u_kvi_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (ratio)
  );

  // Blend as pre + floor((post - pre) * r / 2^FracBits).
  assign comp_a = pre_q.val[comp_q];
  assign comp_b = post_q.val[comp_q];
  assign diff   = $signed({comp_b[ValW-1], comp_b}) - $signed({comp_a[ValW-1], comp_a});
  assign prod_d = ProdW'(diff * $signed({1'b0, ratio}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      addr_q      <= '0;
      default_q   <= '0;
      rd_vld_q    <= 1'b0;
      have_pre_q  <= 1'b0;
      have_post_q <= 1'b0;
      comp_q      <= '0;
      status_q    <= StsDefault;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
      m_user_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        default_q <= cfg_wdata_i;
      end
      if (m_valid_q && m_axis_tready && (state_q != StDone)) begin
        m_valid_q <= 1'b0;
      end
      rd_vld_q <= ram_re;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            unique case (cmd) inside
              CmdLoad: begin
                if (table_full) begin
                  status_q <= StsFull;
                end else begin
                  count_q  <= count_q + 1'b1;
                  status_q <= StsLoaded;
                end
                state_q <= StDone;
              end
              CmdClear: begin
                count_q  <= '0;
                status_q <= StsCleared;
                state_q  <= StDone;
              end
              CmdQuery, CmdQueryAlt: begin
                addr_q      <= '0;
                have_pre_q  <= 1'b0;
                have_post_q <= 1'b0;
                state_q     <= StScan;
              end
              default: begin
                state_q <= StIdle;
              end
            endcase
          end
        end
        StScan: begin
          if (ram_re) begin
            addr_q <= addr_q + 1'b1;
          end
          if (upd_pre) begin
            have_pre_q <= 1'b1;
          end
          if (upd_post) begin
            have_post_q <= 1'b1;
          end
          if (!ram_re && !rd_vld_q) begin
            state_q <= StEval;
          end
        end
        StEval: begin
          if (have_pre_q && have_post_q) begin
            state_q <= StDiv;
          end else begin
            status_q <= (have_pre_q || have_post_q) ? StsHeld : StsDefault;
            state_q  <= StDone;
          end
        end
        StDiv: begin
          if (div_done) begin
            comp_q  <= '0;
            state_q <= StMul;
          end
        end
        StMul: begin
          state_q <= StAdd;
        end
        StAdd: begin
          if (comp_q == 2'd2) begin
            status_q <= StsBlend;
            state_q  <= StDone;
          end else begin
            comp_q  <= comp_q + 1'b1;
            state_q <= StMul;
          end
        end
        StDone: begin
          // Hold the result until the output register is free.
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= res_q;
            m_user_q  <= status_q;
            state_q   <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      t_q   <= s_axis_tdata[ValW-1:0];
      res_q <= '0;
    end
    if (upd_pre) begin
      pre_q <= ram_rdata;
    end
    if (upd_post) begin
      post_q <= ram_rdata;
    end
    if ((state_q == StEval) && !(have_pre_q && have_post_q)) begin
      if (have_pre_q) begin
        res_q <= pre_q.val;
      end else if (have_post_q) begin
        res_q <= post_q.val;
      end else begin
        res_q <= {3{default_q}};
      end
    end
    if (state_q == StMul) begin
      prod_q <= prod_d;
    end
    if (state_q == StAdd) begin
      res_q[comp_q] <= comp_a + prod_q[FracBits +: ValW];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

FILE: hdl/kvi_chk.sv
// ----------------------------------------------------------------------------
// Keyframe vector interpolator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyframe_vector_interpolator_top_macros.svh"

module kvi_chk (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [kvi_pkg::OutW-1:0] m_axis_tdata,
  input logic [kvi_pkg::StsW-1:0] m_axis_tuser
);
  import kvi_pkg::*;

  // A stalled result holds.
  `KVI_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // One request at a time: ready drops right after an accepted request.
  `KVI_ASSERT(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "request accepted while busy")

  // Load, full and clear answers carry zero components.
  `KVI_ASSERT_NEVER(a_zero_data, m_axis_tvalid && (m_axis_tuser == StsLoaded || m_axis_tuser == StsFull || m_axis_tuser == StsCleared) && (m_axis_tdata != '0), "nonzero data on table answer")

  // The default answer repeats one value in all three components.
  `KVI_ASSERT(a_default_same, m_axis_tvalid && (m_axis_tuser == StsDefault) |-> (m_axis_tdata[ValW-1:0] == m_axis_tdata[2*ValW-1:ValW]) && (m_axis_tdata[ValW-1:0] == m_axis_tdata[3*ValW-1:2*ValW]), "default components differ")

endmodule

bind keyframe_vector_interpolator_top kvi_chk u_kvi_chk (.*);

FILE: sim/keyframe_vector_interpolator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe vector interpolator testbench
// Drives load, query and clear requests through the input stream. A local
// key table and blend calculation predict every result, and each received
// result is checked against the oldest prediction. The default value register
// is rewritten between phases, and both streams stall at random outside the final phase.
// ----------------------------------------------------------------------------
module keyframe_vector_interpolator_top_test;
  import kvi_pkg::*;

  typedef struct {
    cmd_e               cmd;
    logic signed [31:0] t;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } kf_request_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    status_e            sts;
  } kf_sample_t;

  localparam logic signed [31:0] TimeMin = 32'sh8000_0000;
  localparam logic signed [31:0] TimeMax = 32'sh7fff_ffff;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [ValW-1:0]   cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [InW-1:0]    s_axis_tdata  = '0;
  logic [CmdW-1:0]   s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OutW-1:0]   m_axis_tdata;
  logic [StsW-1:0]   m_axis_tuser;

  // Key table shadow and default value
  logic signed [31:0] key_tbl_t [KeyDepth];
  logic signed [31:0] key_tbl_x [KeyDepth];
  logic signed [31:0] key_tbl_y [KeyDepth];
  logic signed [31:0] key_tbl_z [KeyDepth];
  int                 keys_held = 0;
  logic signed [31:0] default_value = '0;

  kf_request_t        pending_requests[$];
  kf_sample_t         expected_samples[$];
  kf_request_t        cur_req;
  logic signed [31:0] seq_times[$];
  int                 items_queued = 0;
  int                 errors = 0;
  int                 send_gap = 0;
  int                 recv_gap = 0;
  bit                 send_bursty = 1'b1;
  bit                 recv_bursty = 1'b1;
  bit                 quiet_tail = 1'b0;

  keyframe_vector_interpolator_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // floor((a * (1 - r) + b * r)) in Q16.16, r in Q0.16
  function automatic logic signed [31:0] lerp_q16(logic signed [31:0] a,
                                                  logic signed [31:0] b,
                                                  longint ratio);
    longint acc;
    acc = longint'(a) * (64'sd65536 - ratio) + longint'(b) * ratio;
    return 32'(acc >>> 16);
  endfunction

  function automatic kf_sample_t interpolate_request(kf_request_t req);
    kf_sample_t res;
    bit         have_pre;
    bit         have_post;
    int         pre_idx;
    int         post_idx;
    longint     num;
    longint     den;
    longint     ratio;
    res.x     = '0;
    res.y     = '0;
    res.z     = '0;
    have_pre  = 1'b0;
    have_post = 1'b0;
    pre_idx   = 0;
    post_idx  = 0;
    case (req.cmd)
      CmdLoad: begin
        if (keys_held >= KeyDepth) begin
          res.sts = StsFull;
        end else begin
          key_tbl_t[keys_held] = req.t;
          key_tbl_x[keys_held] = req.x;
          key_tbl_y[keys_held] = req.y;
          key_tbl_z[keys_held] = req.z;
          keys_held++;
          res.sts = StsLoaded;
        end
      end
      CmdClear: begin
        keys_held = 0;
        res.sts   = StsCleared;
      end
      default: begin
        // strict comparisons keep the first stored key on equal times
        for (int i = 0; i < keys_held; i++) begin
          if (key_tbl_t[i] < req.t) begin
            if (!have_pre || key_tbl_t[i] > key_tbl_t[pre_idx]) begin
              pre_idx  = i;
              have_pre = 1'b1;
            end
          end else if (key_tbl_t[i] > req.t) begin
            if (!have_post || key_tbl_t[i] < key_tbl_t[post_idx]) begin
              post_idx  = i;
              have_post = 1'b1;
            end
          end
        end
        if (have_pre && have_post) begin
          num     = longint'(req.t) - longint'(key_tbl_t[pre_idx]);
          den     = longint'(key_tbl_t[post_idx]) - longint'(key_tbl_t[pre_idx]);
          ratio   = (num <<< 16) / den;
          res.x   = lerp_q16(key_tbl_x[pre_idx], key_tbl_x[post_idx], ratio);
          res.y   = lerp_q16(key_tbl_y[pre_idx], key_tbl_y[post_idx], ratio);
          res.z   = lerp_q16(key_tbl_z[pre_idx], key_tbl_z[post_idx], ratio);
          res.sts = StsBlend;
        end else if (have_pre || have_post) begin
          if (!have_pre) pre_idx = post_idx;
          res.x   = key_tbl_x[pre_idx];
          res.y   = key_tbl_y[pre_idx];
          res.z   = key_tbl_z[pre_idx];
          res.sts = StsHeld;
        end else begin
          res.x   = default_value;
          res.y   = default_value;
          res.z   = default_value;
          res.sts = StsDefault;
        end
      end
    endcase
    return res;
  endfunction

  // Request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_samples.insert(expected_samples.size(), interpolate_request(cur_req));
        if ($urandom_range(0, 29) == 0) send_bursty = !send_bursty;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the request until taken
      end else if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap--;
      end else if (pending_requests.size() > 0) begin
        cur_req = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cur_req.z, cur_req.y, cur_req.x, cur_req.t};
        s_axis_tuser  <= cur_req.cmd;
        if (!quiet_tail && send_bursty && $urandom_range(0, 3) == 0)
          send_gap = $urandom_range(1, 18);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_val, act_val);
      errors++;
    end
  endtask

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result: data %h, status %0d", m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          check_field("out_x", expected_samples[0].x, m_axis_tdata[31:0]);
          check_field("out_y", expected_samples[0].y, m_axis_tdata[63:32]);
          check_field("out_z", expected_samples[0].z, m_axis_tdata[95:64]);
          check_field("status", 32'(expected_samples[0].sts), 32'(m_axis_tuser));
          void'(expected_samples.pop_front());
        end
        if ($urandom_range(0, 29) == 0) recv_bursty = !recv_bursty;
      end
      if (recv_gap > 0) begin
        m_axis_tready <= 1'b0;
        recv_gap--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet_tail && recv_bursty && $urandom_range(0, 4) == 0)
          recv_gap = $urandom_range(1, 18);
      end
    end
  end

  task automatic push_req(cmd_e cmd, logic signed [31:0] t, logic signed [31:0] x,
                          logic signed [31:0] y, logic signed [31:0] z);
    kf_request_t req;
    req.cmd = cmd;
    req.t   = t;
    req.x   = x;
    req.y   = y;
    req.z   = z;
    pending_requests.insert(pending_requests.size(), req);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_samples.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_default(logic signed [31:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    default_value = value;
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return $urandom_range(0, 262144) - 131072;
  endfunction

  function automatic logic signed [31:0] pick_key_time(int scheme);
    case (scheme)
      0:       return $urandom;
      1:       return $urandom_range(0, 40) - 20;
      default: return $urandom_range(0, 2000) * 1000 - 1000000;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_query_time();
    logic signed [31:0] a;
    logic signed [31:0] b;
    longint             lo;
    longint             span;
    if (seq_times.size() == 0) return $urandom;
    a = seq_times[$urandom_range(0, seq_times.size() - 1)];
    b = seq_times[$urandom_range(0, seq_times.size() - 1)];
    case ($urandom_range(0, 6))
      0, 1: return a;
      2:    return a + 1;
      3:    return a - 1;
      4: begin
        lo   = (a < b) ? longint'(a) : longint'(b);
        span = ((a < b) ? longint'(b) : longint'(a)) - lo + 1;
        return 32'(lo + longint'($urandom) % span);
      end
      5:    return $urandom;
      default: return $urandom_range(0, 1) ? TimeMax : TimeMin;
    endcase
  endfunction

  // Optional clear, a run of loads, then queries around the loaded times
  task automatic gen_sequence(int n_keys, bit force_clear);
    int                 scheme;
    logic signed [31:0] t;
    scheme = $urandom_range(0, 2);
    seq_times.delete();
    if (force_clear || $urandom_range(0, 9) != 0)
      push_req(CmdClear, $urandom, $urandom, $urandom, $urandom);
    repeat (n_keys) begin
      t = pick_key_time(scheme);
      seq_times.insert(seq_times.size(), t);
      push_req(CmdLoad, t, pick_value(), pick_value(), pick_value());
    end
    repeat ($urandom_range(2, 6))
      push_req($urandom_range(0, 5) == 0 ? CmdQueryAlt : CmdQuery, pick_query_time(),
               $urandom, $urandom, $urandom);
  endtask

  task automatic run_random_phase(int n_items);
    int target;
    target = items_queued + n_items;
    while (items_queued < target) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3))
          push_req(cmd_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
      end else if ($urandom_range(0, 9) == 0) begin
        gen_sequence($urandom_range(28, 36), 1'b0);
      end else begin
        gen_sequence($urandom_range(0, 8), 1'b0);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_default(32'sd65536);

    // empty table, extreme times and values, ties, equal time, alternate query
    push_req(CmdQuery, 32'sd0, '0, '0, '0);
    push_req(CmdClear, 32'sd0, '1, '1, '1);
    push_req(CmdLoad, TimeMin, TimeMin, TimeMax, 32'sd0);
    push_req(CmdLoad, TimeMax, TimeMax, TimeMin, -32'sd1);
    push_req(CmdQuery, 32'sd0, '0, '0, '0);
    push_req(CmdQuery, TimeMin, '0, '0, '0);
    push_req(CmdQuery, TimeMax, '0, '0, '0);
    push_req(CmdQueryAlt, TimeMin + 1, '1, '1, '1);
    push_req(CmdQuery, TimeMax - 1, '0, '0, '0);
    push_req(CmdLoad, 32'sd100, 32'sd1, 32'sd2, 32'sd3);
    push_req(CmdLoad, 32'sd100, 32'sd7, 32'sd8, 32'sd9);
    push_req(CmdQuery, 32'sd150, '0, '0, '0);
    push_req(CmdQuery, 32'sd50, '0, '0, '0);
    push_req(CmdQuery, 32'sd100, '0, '0, '0);
    push_req(CmdClear, 32'sd0, '0, '0, '0);
    push_req(CmdLoad, 32'sd10, 32'sd65536, -32'sd65536, 32'sd131072);
    push_req(CmdQuery, 32'sd10, '0, '0, '0);
    push_req(CmdLoad, -32'sd5, -32'sd1, 32'sd1, 32'sd0);
    push_req(CmdQueryAlt, 32'sd0, '0, '0, '0);
    push_req(CmdQuery, 32'sd20, '0, '0, '0);
    wait_idle();

    write_default(TimeMin);
    gen_sequence(34, 1'b1);
    run_random_phase(160);
    wait_idle();
    write_default(TimeMax);
    run_random_phase(195);
    wait_idle();
    write_default(32'sd0);
    run_random_phase(195);
    wait_idle();
    write_default($urandom);
    quiet_tail = 1'b1;
    run_random_phase(195);
    wait_idle();

    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
